// ===== hdl/rcd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcd_pkg
// Types, sizes and helpers shared by the reversible character deque.
// ----------------------------------------------------------------------------
package rcd_pkg;

    // Store size and the widths that follow from it
    localparam int DEPTH = 1024;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Field widths of the channels
    localparam int OP_W     = 2;
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 10;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 11;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_REV  = 2'd1,
        OP_READ = 2'd2
    } op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // Item in flight while its store read completes
    typedef struct packed {
        status_t             status;
        cnt_t                fill;
        logic                rev;
        logic                rd_ok;
    } stage_t;

    // Result held for the receiver
    typedef struct packed {
        logic [BYTE_W-1:0]   byte_out;
        status_t             status;
        cnt_t                fill;
        logic                rev;
    } result_t;

    // Circular add of two in-range slot offsets
    function automatic ptr_t wrap_add(input ptr_t a, input ptr_t b);
        logic [PTR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (PTR_W+1)'(DEPTH))
        begin
            s = s - (PTR_W+1)'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

// ===== hdl/rcd_if.sv =====
// ----------------------------------------------------------------------------
// rcd_if
// Valid/ready channels for deque items and their results.
// ----------------------------------------------------------------------------
interface rcd_item_if import rcd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic              side;
    logic [BYTE_W-1:0] byte_in;
    logic [POS_W-1:0]  position;

    modport source (output valid, op, side, byte_in, position, input ready);
    modport sink   (input valid, op, side, byte_in, position, output ready);
endinterface

interface rcd_result_if import rcd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   byte_out;
    logic [STATUS_W-1:0] status;
    logic [FILL_W-1:0]   fill;
    logic                reversed;

    modport source (output valid, byte_out, status, fill, reversed, input ready);
    modport sink   (input valid, byte_out, status, fill, reversed, output ready);
endinterface

// ===== hdl/rcd_ram.sv =====
// ----------------------------------------------------------------------------
// rcd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; hold data when idle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/reversible_char_deque.sv =====
// ----------------------------------------------------------------------------
// reversible_char_deque
// Byte deque in a circular store with a lazy reversal flag.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready channel of commands (push a byte at a side, toggle
//            reversal, read a logical position). A transfer takes place on a
//            rising edge with valid and ready both high.
//   result : valid/ready channel; exactly one result per item, in order,
//            carrying the byte read, a status code, the fill after the item
//            and the reversal flag after the item.
//   Throughput is one item per cycle. Pointers and the count update in the
//   cycle of the transfer; a push writes the store at that edge and a read
//   issues its address then. The store's registered read port feeds the
//   result register: an item passes the read stage, where the store's read
//   data is registered, and then the result register before it is offered.
//   A stalled receiver holds the result register; one further item waits in
//   the read stage, after which item.ready drops until the result moves.
//   Reset empties the deque and clears the reversal flag at once; no
//   clearing pass runs, since a read only reaches bytes that a push wrote.
// ----------------------------------------------------------------------------
module reversible_char_deque import rcd_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    rcd_item_if.sink      item,
    rcd_result_if.source  result
);

    ptr_t    head_reg, head_next;
    cnt_t    cnt_reg, cnt_next;
    logic    rev_reg, rev_next;

    logic    s1_vld_reg;
    stage_t  s1_reg, s1_next;
    logic    out_vld_reg;
    result_t out_reg;

    logic    accept, out_adv, s1_adv;
    logic    full, eff_side, in_range;
    cnt_t    pos_ext, idx;
    op_t     op;

    logic              ram_we, ram_re;
    ptr_t              ram_waddr, ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    // Handshake
    assign out_adv     = !out_vld_reg || result.ready;
    assign s1_adv      = s1_vld_reg && out_adv;
    assign item.ready  = !s1_vld_reg || out_adv;
    assign accept      = item.valid && item.ready;

    // Decode the item against the current state
    assign op       = op_t'(item.op);
    assign full     = (cnt_reg >= CNT_W'(DEPTH));
    assign eff_side = item.side ^ rev_reg;
    assign pos_ext  = CNT_W'(item.position);
    assign in_range = (pos_ext < cnt_reg);
    assign idx      = rev_reg ? (cnt_reg - CNT_W'(1) - pos_ext) : pos_ext;

    always_comb
    begin
        head_next     = head_reg;
        cnt_next      = cnt_reg;
        rev_next      = rev_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = head_reg;
        ram_raddr     = wrap_add(head_reg, idx[PTR_W-1:0]);
        s1_next.status = ST_OK;
        s1_next.rd_ok  = 1'b0;
        unique case (op)
            OP_PUSH:
            begin
                if (full)
                begin
                    s1_next.status = ST_FULL;
                end
                else if (!eff_side)
                begin
                    // front: step head back and write there
                    head_next = (head_reg == '0) ? PTR_W'(DEPTH - 1)
                                                 : head_reg - PTR_W'(1);
                    ram_waddr = head_next;
                    ram_we    = accept;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    // back: write just past the last byte
                    ram_waddr = wrap_add(head_reg, cnt_reg[PTR_W-1:0]);
                    ram_we    = accept;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
            end
            OP_REV:
            begin
                rev_next = !rev_reg;
            end
            OP_READ:
            begin
                if (in_range)
                begin
                    ram_re        = accept;
                    s1_next.rd_ok = 1'b1;
                end
                else
                begin
                    s1_next.status = ST_RANGE;
                end
            end
            default:
            begin
                // unused code: no effect
            end
        endcase
        s1_next.fill = cnt_next;
        s1_next.rev  = rev_next;
    end

    // Byte store
    rcd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item.byte_in),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Advance deque state on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            cnt_reg  <= '0;
            rev_reg  <= 1'b0;
        end
        else if (accept)
        begin
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
            rev_reg  <= rev_next;
        end
    end

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_vld_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_vld_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_adv)
        begin
            out_reg.byte_out <= s1_reg.rd_ok ? ram_rdata : '0;
            out_reg.status   <= s1_reg.status;
            out_reg.fill     <= s1_reg.fill;
            out_reg.rev      <= s1_reg.rev;
        end
    end

    // Drive the result channel
    assign result.valid    = out_vld_reg;
    assign result.byte_out = out_reg.byte_out;
    assign result.status   = out_reg.status;
    assign result.fill     = FILL_W'(out_reg.fill);
    assign result.reversed = out_reg.rev;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("deque count exceeds store depth");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        accept && op == OP_PUSH && full |=> s1_vld_reg && s1_reg.status == ST_FULL
            && $stable(cnt_reg) && $stable(head_reg))
        else $error("push into full store not dropped");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(cnt_reg) && $stable(head_reg) && $stable(rev_reg))
        else $error("deque state changed without a transfer");

    a_read_issue: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> accept && op == OP_READ && !ram_we)
        else $error("store read issued outside a read transfer");
`endif

endmodule
